FILE: hdl/rbns_pkg.sv
package rbns_pkg;

  localparam int unsigned NODES_DEF  = 9;
  localparam int unsigned WINDOW_DEF = 8;

  localparam int unsigned NODE_W = 4;
  localparam int unsigned RSSI_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RSSI      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_NODE = 2'd1;

  localparam logic [RSSI_W-1:0] MIN_RSSI_RST      = 8'h80;
  localparam logic [NODE_W-1:0] FALLBACK_NODE_RST = 4'd1;

  typedef struct packed {
    logic latch_in;
    logic upd;
    logic scan_init;
    logic scan_next;
    logic div_start;
    logic div_step;
    logic cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic node_ok;
    logic qual;
    logic last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/rbns_ram.sv
module rbns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 72
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rbns_ctrl.sv
module rbns_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rbns_pkg::status_t stat_i,
  output rbns_pkg::cmd_t   cmd_o
);
  import rbns_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_CMP  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.scan_init = 1'b1;
        state_d = stat_i.node_ok ? ST_UPD : ST_SCAN;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.qual) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else if (stat_i.last) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (stat_i.last) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: hdl/rbns_datapath.sv
module rbns_datapath #(
  parameter int unsigned NODES  = rbns_pkg::NODES_DEF,
  parameter int unsigned WINDOW = rbns_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rbns_pkg::cmd_t                   cmd_i,
  output rbns_pkg::status_t                stat_o,
  input  logic [rbns_pkg::NODE_W-1:0]      node_index_i,
  input  logic signed [rbns_pkg::RSSI_W-1:0] strength_i,
  input  logic                             cfg_valid_i,
  input  logic [rbns_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rbns_pkg::RSSI_W-1:0]      cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rbns_pkg::NODE_W-1:0]      best_node_o,
  output logic signed [rbns_pkg::RSSI_W-1:0] best_mean_o,
  output logic                             found_o
);
  import rbns_pkg::*;

  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned CW  = $clog2(WINDOW + 1);
  localparam int unsigned HW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SW  = RSSI_W + $clog2(WINDOW);
  localparam int unsigned DW  = $clog2(SW);
  localparam int unsigned DEP = NODES * WINDOW;
  localparam int unsigned AW  = $clog2(DEP);
  localparam logic [AW-1:0] WIN_A = AW'(WINDOW);
  localparam logic [CW-1:0] WIN_C = CW'(WINDOW);
  localparam logic [HW-1:0] HEAD_LAST = HW'(WINDOW - 1);

  logic [NODE_W-1:0]        node_q;
  logic signed [RSSI_W-1:0] str_q;
  logic [RSSI_W-1:0]        min_rssi_q;
  logic [NODE_W-1:0]        fallback_q;

  logic signed [SW-1:0] sum_q  [NODES];
  logic [CW-1:0]        cnt_q  [NODES];
  logic [HW-1:0]        head_q [NODES];
  logic [CW-1:0]        age_q  [NODES];

  logic [NW-1:0]            idx_q;
  logic signed [RSSI_W-1:0] best_q;
  logic [NODE_W-1:0]        bnode_q;
  logic                     found_q;

  logic [CW-1:0] rem_q;
  logic [SW-1:0] quo_q;
  logic [DW-1:0] dcnt_q;
  logic          neg_q;

  logic                     out_valid_q;
  logic [NODE_W-1:0]        out_node_q;
  logic signed [RSSI_W-1:0] out_mean_q;
  logic                     out_found_q;

  logic [NW-1:0]        nidx;
  logic                 node_ok;
  logic [AW-1:0]        addr;
  logic signed [RSSI_W-1:0] old_s;
  logic signed [SW-1:0] sum_sel;
  logic [SW-1:0]        sum_mag;
  logic [CW:0]          rem_sh;
  logic                 ge;
  logic [CW:0]          rem_sub;
  logic [SW-1:0]        mean_w;
  logic signed [RSSI_W-1:0] mean;

  assign node_ok = ({1'b0, node_q} < (NODE_W + 1)'(NODES));
  assign nidx    = node_q[NW-1:0];
  assign addr    = node_ok ? (AW'(nidx) * WIN_A + AW'(head_q[nidx])) : '0;

  rbns_ram #(.WIDTH(RSSI_W), .DEPTH(DEP)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (addr),
    .wdata_i (str_q),
    .raddr_i (addr),
    .rdata_o (old_s)
  );

  // divider: restoring, one quotient bit per cycle on magnitudes
  assign sum_sel = sum_q[idx_q];
  assign sum_mag = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
  assign rem_sh  = {rem_q, quo_q[SW-1]};
  assign ge      = (rem_sh >= {1'b0, cnt_q[idx_q]});
  assign rem_sub = rem_sh - {1'b0, cnt_q[idx_q]};
  assign mean_w  = neg_q ? SW'(-quo_q) : quo_q;
  assign mean    = mean_w[RSSI_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      node_q <= node_index_i;
      str_q  <= strength_i;
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= sum_mag;
      dcnt_q <= DW'(SW - 1);
      neg_q  <= sum_sel[SW-1];
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      quo_q  <= {quo_q[SW-2:0], ge};
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      out_node_q  <= bnode_q;
      out_mean_q  <= best_q;
      out_found_q <= found_q;
    end
    if (cmd_i.scan_init) begin
      idx_q   <= '0;
      best_q  <= min_rssi_q;
      bnode_q <= fallback_q;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.cmp && (mean > best_q)) begin
        best_q  <= mean;
        bnode_q <= NODE_W'(idx_q);
        found_q <= 1'b1;
      end
      if (cmd_i.scan_next) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rssi_q  <= MIN_RSSI_RST;
      fallback_q  <= FALLBACK_NODE_RST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        age_q[i]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MIN_RSSI:      min_rssi_q <= cfg_data_i;
          CFG_FALLBACK_NODE: fallback_q <= cfg_data_i[NODE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.out_load)                  out_valid_q <= 1'b1;
      else if (out_ready_i)                out_valid_q <= 1'b0;
      if (cmd_i.upd) begin
        for (int i = 0; i < NODES; i++) begin
          if (NW'(i) == nidx)     age_q[i] <= WIN_C;
          else if (age_q[i] != '0) age_q[i] <= age_q[i] - 1'b1;
        end
        // full window drops the oldest word, which sits at the head slot
        sum_q[nidx]  <= sum_q[nidx] + SW'(str_q)
                        - ((cnt_q[nidx] == WIN_C) ? SW'(old_s) : '0);
        head_q[nidx] <= (head_q[nidx] == HEAD_LAST) ? '0 : head_q[nidx] + 1'b1;
        if (cnt_q[nidx] != WIN_C) cnt_q[nidx] <= cnt_q[nidx] + 1'b1;
      end
    end
  end

  assign stat_o.node_ok  = node_ok;
  assign stat_o.qual     = (cnt_q[idx_q] != '0) && (age_q[idx_q] != '0);
  assign stat_o.last     = (idx_q == NW'(NODES - 1));
  assign stat_o.div_last = (dcnt_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign best_node_o = out_node_q;
  assign best_mean_o = out_mean_q;
  assign found_o     = out_found_q;

endmodule

FILE: hdl/rssi_best_node_selector_unit.sv
// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_ready_o | node_index_i, strength_i
// out      | output    | out_valid_o/out_ready_i | best_node_o, best_mean_o, found_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word at a time: the window of a node in range is read and updated, then each
// node is scanned in turn and every live node goes through the shared serial divider,
// then the result is loaded into the output register once that register is free.
// reset clears all counts, ages and window sums; no sweep is needed.
// a stalled output holds the finished word while the next input is taken.
module rssi_best_node_selector_unit #(
  parameter int unsigned NODES  = rbns_pkg::NODES_DEF,
  parameter int unsigned WINDOW = rbns_pkg::WINDOW_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rbns_pkg::NODE_W-1:0]        node_index_i,
  input  logic signed [rbns_pkg::RSSI_W-1:0] strength_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rbns_pkg::NODE_W-1:0]        best_node_o,
  output logic signed [rbns_pkg::RSSI_W-1:0] best_mean_o,
  output logic                               found_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rbns_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rbns_pkg::RSSI_W-1:0]        cfg_data_i
);
  import rbns_pkg::*;

  cmd_t    cmd;
  status_t stat;

  assign cfg_ready_o = 1'b1;

  rbns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rbns_datapath #(.NODES(NODES), .WINDOW(WINDOW)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .node_index_i (node_index_i),
    .strength_i   (strength_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_node_o  (best_node_o),
    .best_mean_o  (best_mean_o),
    .found_o      (found_o)
  );

endmodule
